// File: rtl/orb_pkg.sv
// Shared constants, types and helpers of the overwrite ring buffer.
`default_nettype none
package orb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int MAX_READ   = 64;
  localparam int CNT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int LIMIT_W    = 15;
  localparam int FILL_W     = 8;
  localparam int FILL_MAX   = 255;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QLVL_W     = 2;

  localparam logic [LIMIT_W-1:0] CLAMP_RESET = 15'd4096;

  // Register index of clamp_limit, taken from paddr[2]
  localparam logic REG_CLAMP = 1'b0;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]           count;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       valid_res;
    logic                       last;
    logic                       overflow;
    logic [FILL_W-1:0]          fill_level;
  } res_t;

  function automatic logic [FILL_W-1:0] sat_fill(input logic [PTR_W-1:0] a);
    if (32'(a) > 32'(FILL_MAX)) begin
      return FILL_W'(FILL_MAX);
    end else begin
      return FILL_W'(a);
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/orb_if.sv
// Request and response channel interfaces.
`default_nettype none
interface orb_req_if import orb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [CNT_W-1:0]           read_count;

  modport source (output valid, mode, sample_in, read_count, input ready);
  modport sink   (input valid, mode, sample_in, read_count, output ready);
endinterface

interface orb_rsp_if import orb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       valid_res;
  logic                       last;
  logic                       overflow;
  logic [FILL_W-1:0]          fill_level;

  modport source (output valid, sample_out, valid_res, last, overflow, fill_level,
                  input ready);
  modport sink   (input valid, sample_out, valid_res, last, overflow, fill_level,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/overwrite_ring_buffer_top.sv
// Top level of the overwrite ring buffer.
//
//   port      dir    word
//   req       in     mode, sample_in, read_count
//   rsp       out    sample_out, valid_res, last, overflow, fill_level
//   apb       in     clamp_limit at byte address 0
//
// A write word yields one result, registered in the back end and then queued.
// A read word first sizes its run, then reads one sample whenever there is room:
// a result in flight plus one held in the result queue stall the back end.
// The back end runs one word at a time.
// Reset clears the ring positions and queues at once; memory is not cleared.
// A stalled rsp backs up into the two-entry command queue, then req.ready drops.
`default_nettype none
module overwrite_ring_buffer_top import orb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  orb_req_if.sink                 req,
  orb_rsp_if.source               rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  logic [QLVL_W-1:0] oq_level;
  logic              res_valid;
  res_t              res;

  orb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  orb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_level  (oq_level),
    .res_valid (res_valid),
    .res       (res)
  );

  orb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .level     (oq_level),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// File: rtl/orb_front.sv
// Front end: register port, sample clamp, count saturation and command queue.
`default_nettype none
module orb_front import orb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  orb_req_if.sink                 req,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  wire logic               cmd_pop
);

  logic [LIMIT_W-1:0] clamp_limit;
  cmd_t               q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QLVL_W-1:0]  level;
  logic               push;
  cmd_t               cls;
  logic signed [SAMPLE_W:0] s_ext;
  logic signed [SAMPLE_W:0] lim_ext;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= CLAMP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CLAMP) begin
      clamp_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CLAMP) begin
      prdata = PDATA_W'(clamp_limit);
    end
  end

  // Classify: clamp writes, saturate read counts
  always_comb begin
    s_ext   = (SAMPLE_W+1)'(req.sample_in);
    lim_ext = $signed({2'b00, clamp_limit});
    cls.mode   = req.mode;
    cls.sample = req.sample_in;
    if (s_ext > lim_ext) begin
      cls.sample = SAMPLE_W'(lim_ext);
    end else if (s_ext < -lim_ext) begin
      cls.sample = SAMPLE_W'(-lim_ext);
    end
    cls.count = req.read_count;
    if (32'(req.read_count) > MAX_READ) begin
      cls.count = CNT_W'(MAX_READ);
    end
  end

  assign req.ready = (level != QLVL_W'(QDEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (level != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + QLVL_W'(push) - QLVL_W'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/orb_back.sv
// Back end: sample memory, ring positions and the read sequencer.
`default_nettype none
module orb_back import orb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  input  wire logic [QLVL_W-1:0] oq_level,
  output logic                   res_valid,
  output res_t                   res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t                    state;
  logic [SAMPLE_W-1:0]       mem [RING_DEPTH];
  logic [SAMPLE_W-1:0]       mem_q;
  logic [PTR_W-1:0]          wp;
  logic [PTR_W-1:0]          rp;
  logic [CNT_W-1:0]          remaining;
  logic                      s1_valid;
  logic                      s1_from_mem;
  logic                      s1_last;
  logic                      s1_ovf;
  logic [FILL_W-1:0]         s1_fill;

  logic                      space;
  logic [PTR_W-1:0]          avail;
  logic [PTR_W-1:0]          wp_next;
  logic [PTR_W-1:0]          rp_next;
  logic                      ovf_next;
  logic [CNT_W-1:0]          n_next;
  logic                      do_write;
  logic                      do_rd;

  // Room downstream for one more result counting the one in flight
  assign space = (32'(oq_level) + 32'(s1_valid)) < QDEPTH;
  assign avail = wp - rp;

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid && space;
  assign do_write = cmd_pop && (cmd.mode == MODE_WRITE);
  assign do_rd    = (state == ST_READ) && space;

  always_comb begin
    wp_next  = wp + 1'b1;
    rp_next  = rp;
    ovf_next = 1'b0;
    if (wp_next == rp) begin
      rp_next  = rp + 1'b1;
      ovf_next = 1'b1;
    end
    n_next = cmd.count;
    if (32'(avail) < 32'(cmd.count)) begin
      n_next = CNT_W'(avail);
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wp] <= cmd.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      mem_q <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      remaining <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd.mode == MODE_WRITE) begin
              wp       <= wp_next;
              rp       <= rp_next;
              s1_valid <= 1'b1;
            end else if (n_next == '0) begin
              s1_valid <= 1'b1;
            end else begin
              remaining <= n_next;
              state     <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (do_rd) begin
            rp        <= rp + 1'b1;
            remaining <= remaining - 1'b1;
            s1_valid  <= 1'b1;
            if (remaining == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result metadata, aligned with the registered memory read
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_from_mem <= 1'b0;
      s1_last     <= 1'b1;
      if (cmd.mode == MODE_WRITE) begin
        s1_ovf  <= ovf_next;
        s1_fill <= sat_fill(wp_next - rp_next);
      end else begin
        s1_ovf  <= 1'b0;
        s1_fill <= sat_fill(avail);
      end
    end else if (do_rd) begin
      s1_from_mem <= 1'b1;
      s1_last     <= (remaining == CNT_W'(1));
      s1_ovf      <= 1'b0;
      s1_fill     <= sat_fill(avail - 1'b1);
    end
  end

  assign res_valid      = s1_valid;
  assign res.sample_out = s1_from_mem ? mem_q : '0;
  assign res.valid_res  = s1_from_mem;
  assign res.last       = s1_last;
  assign res.overflow   = s1_ovf;
  assign res.fill_level = s1_fill;

endmodule
`default_nettype wire

// File: rtl/orb_outq.sv
// Two-entry result queue that drives the response channel.
`default_nettype none
module orb_outq import orb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         res_valid,
  input  wire res_t         res,
  output logic [QLVL_W-1:0] level,
  orb_rsp_if.source         rsp
);

  res_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;
  res_t              head;

  assign head           = q[rd_ptr];
  assign rsp.valid      = (level != '0);
  assign rsp.sample_out = head.sample_out;
  assign rsp.valid_res  = head.valid_res;
  assign rsp.last       = head.last;
  assign rsp.overflow   = head.overflow;
  assign rsp.fill_level = head.fill_level;
  assign pop            = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + QLVL_W'(res_valid) - QLVL_W'(pop);
    end
  end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the overwrite ring buffer: predictor, stimulus and result checks.
`timescale 1ns / 100ps

import orb_pkg::*;

class ring_tracker;
  logic [SAMPLE_W-1:0] store [RING_DEPTH];
  logic [PTR_W-1:0]    wr_pos;
  logic [PTR_W-1:0]    rd_pos;
  logic [LIMIT_W-1:0]  limit;
  res_t                pending [$];
  int                  errors;
  int                  drops;

  function new();
    wr_pos = '0;
    rd_pos = '0;
    limit  = CLAMP_RESET;
    errors = 0;
    drops  = 0;
  endfunction

  function logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % RING_DEPTH);
  endfunction

  function int stored();
    return (int'(wr_pos) - int'(rd_pos) + RING_DEPTH) % RING_DEPTH;
  endfunction

  function logic [FILL_W-1:0] fill();
    return FILL_W'((stored() > FILL_MAX) ? FILL_MAX : stored());
  endfunction

  function void set_limit(input logic index, input logic [PDATA_W-1:0] data);
    if (index == REG_CLAMP) begin
      limit = data[LIMIT_W-1:0];
    end
  endfunction

  // Work out the results of one accepted word and queue them.
  function void note_word(input logic mode, input logic signed [SAMPLE_W-1:0] smp,
                          input logic [CNT_W-1:0] cnt);
    res_t r;
    int   val;
    int   n;
    r = '0;
    if (mode == MODE_WRITE) begin
      val = smp;
      if (val > int'(limit)) val = int'(limit);
      if (val < -int'(limit)) val = -int'(limit);
      store[wr_pos] = SAMPLE_W'(val);
      wr_pos = advance(wr_pos);
      r.last = 1'b1;
      // drop the oldest sample when the write index lands on the read index
      if (wr_pos == rd_pos) begin
        rd_pos = advance(rd_pos);
        r.overflow = 1'b1;
        drops++;
      end
      r.fill_level = fill();
      pending.push_back(r);
    end else begin
      n = (int'(cnt) > MAX_READ) ? MAX_READ : int'(cnt);
      if (stored() < n) n = stored();
      if (n == 0) begin
        r.last = 1'b1;
        r.fill_level = fill();
        pending.push_back(r);
      end
      for (int i = 0; i < n; i++) begin
        r.sample_out = store[rd_pos];
        rd_pos = advance(rd_pos);
        r.valid_res  = 1'b1;
        r.last       = (i == n - 1);
        r.fill_level = fill();
        pending.push_back(r);
      end
    end
  endfunction

  function void compare(input string name, input logic [SAMPLE_W-1:0] want,
                        input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(input res_t got);
    res_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing expected, expected none got %0h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare("sample_out", want.sample_out, got.sample_out);
    compare("valid_res", SAMPLE_W'(want.valid_res), SAMPLE_W'(got.valid_res));
    compare("last", SAMPLE_W'(want.last), SAMPLE_W'(got.last));
    compare("overflow", SAMPLE_W'(want.overflow), SAMPLE_W'(got.overflow));
    compare("fill_level", SAMPLE_W'(want.fill_level), SAMPLE_W'(got.fill_level));
  endfunction
endclass

module testbench;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam logic [PADDR_W-1:0] ADDR_CLAMP = {REG_CLAMP, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_CLAMP, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          send_idle_pct = 38;
  int          recv_idle_pct = 57;
  int          quiet_cycles  = 0;
  int          base_drops;
  ring_tracker tracker;

  orb_req_if req_ch ();
  orb_rsp_if rsp_ch ();

  overwrite_ring_buffer_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_result(res_t'({rsp_ch.sample_out, rsp_ch.valid_res, rsp_ch.last,
                                   rsp_ch.overflow, rsp_ch.fill_level}));
    end
  end

  // Count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic mode, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.sample_in  <= smp;
    req_ch.read_count <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_word(mode, smp, cnt);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_limit(addr[2], data);
  endtask

  task automatic check_clamp_readback();
    logic [PDATA_W-1:0] want;
    want    = PDATA_W'(tracker.limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CLAMP;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== want) begin
      $display("%0t: clamp_limit readback expected %0h got %0h", $time, want, prdata);
      tracker.errors++;
    end
  endtask

  task automatic set_clamp(input logic [PDATA_W-1:0] data);
    apb_write(ADDR_CLAMP, data);
    check_clamp_readback();
  endtask

  // Hold off until every expected result is out, then let the back end settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int lim;
    lim = int'(tracker.limit);
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'(lim);
      3: return SAMPLE_W'(-lim);
      4: return SAMPLE_W'(lim + 1);
      5: return SAMPLE_W'(-lim - 1);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic random_word(input int write_pct);
    logic             mode;
    logic [CNT_W-1:0] cnt;
    mode = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
    cnt  = ($urandom_range(2) == 0) ? CNT_W'($urandom_range(127))
                                    : CNT_W'($urandom_range(1, 16));
    send_word(mode, pick_sample(), cnt);
  endtask

  initial begin
    tracker = new();
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_WRITE;
    req_ch.sample_in  <= '0;
    req_ch.read_count <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset limit.
    check_clamp_readback();
    send_word(MODE_READ, '0, CNT_W'(5));
    send_word(MODE_READ, '0, CNT_W'(0));
    send_word(MODE_WRITE, 16'sh7FFF, '0);
    send_word(MODE_WRITE, 16'sh8000, CNT_W'(127));
    send_word(MODE_WRITE, 16'sd4096, '0);
    send_word(MODE_WRITE, -16'sd4096, '0);
    send_word(MODE_WRITE, 16'sd4097, '0);
    send_word(MODE_WRITE, -16'sd4097, '0);
    send_word(MODE_WRITE, 16'sd0, '0);
    send_word(MODE_WRITE, -16'sd1, '0);
    send_word(MODE_READ, 16'sh7FFF, CNT_W'(3));
    send_word(MODE_READ, '0, CNT_W'(0));
    send_word(MODE_READ, '0, CNT_W'(127));
    send_word(MODE_READ, '0, CNT_W'(5));
    wait_idle();

    // Zero limit stores every sample as zero.
    set_clamp(32'h0000_0000);
    send_word(MODE_WRITE, 16'sh7FFF, '0);
    send_word(MODE_WRITE, 16'sh8000, '0);
    send_word(MODE_WRITE, 16'sd7, '0);
    send_word(MODE_READ, '0, CNT_W'(64));
    wait_idle();

    // Widest limit; bits above the register are dropped.
    set_clamp(32'hFFFF_FFFF);
    send_word(MODE_WRITE, 16'sh7FFF, '0);
    send_word(MODE_WRITE, 16'sh8000, '0);
    send_word(MODE_WRITE, -16'sd32767, '0);
    send_word(MODE_WRITE, 16'sd1, '0);
    send_word(MODE_READ, '0, CNT_W'(127));
    wait_idle();

    // A write to an unmapped index leaves the limit alone.
    apb_write(ADDR_SPARE, 32'h0000_0010);
    check_clamp_readback();
    send_word(MODE_WRITE, 16'sh8000, '0);
    send_word(MODE_READ, '0, CNT_W'(2));
    wait_idle();

    set_clamp(PDATA_W'({$urandom, 15'(0)}) | PDATA_W'($urandom_range(2, 32766)));
    repeat (35) random_word(60);
    wait_idle();

    // Fill the ring past the wrap so the oldest samples get dropped.
    send_idle_pct = 57;
    recv_idle_pct = 38;
    set_clamp(PDATA_W'({$urandom, 15'(0)}) | PDATA_W'($urandom_range(2, 32766)));
    base_drops = tracker.drops;
    while (tracker.drops < base_drops + 8) begin
      if ($urandom_range(49) == 0) begin
        send_word(MODE_READ, pick_sample(), CNT_W'($urandom_range(1, 3)));
      end else begin
        send_word(MODE_WRITE, pick_sample(), CNT_W'($urandom_range(127)));
      end
    end
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_clamp(32'h0000_0001);
    repeat (30) random_word(35);
    wait_idle();

    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
